### hw/rtl/merge_sorter_unit_macros.svh
// ----------------------------------------------------------------------------
// merge sorter assertion macros
// shared concurrent assertion wrappers clocked on aclk
// ----------------------------------------------------------------------------
`ifndef MERGE_SORTER_UNIT_MACROS_SVH
`define MERGE_SORTER_UNIT_MACROS_SVH

// property checked on every rising edge outside reset
`define MSRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define MSRT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### hw/rtl/msrt_pkg.sv
// ----------------------------------------------------------------------------
// msrt_pkg
// beat types, cell control and state codes for the merge sorter
// ----------------------------------------------------------------------------
package msrt_pkg;

    // input beat
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_out;
    } out_beat_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

    // load / drain phases, one-hot
    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

### hw/rtl/msrt_cell.sv
// ----------------------------------------------------------------------------
// msrt_cell
// one slot of the sorting chain: holds a value, takes an insert or a shift
// ----------------------------------------------------------------------------
module msrt_cell
    import msrt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctrl_t         ctrl,
    input  logic signed [31:0] ins_value,
    input  logic               left_gt,
    input  logic signed [31:0] left_value,
    input  logic               left_valid,
    input  logic signed [31:0] right_value,
    input  logic               right_valid,
    output logic signed [31:0] value,
    output logic               valid,
    output logic               gt
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               valid_reg;
    logic               valid_next;

    // empty slots count as greater; equal held value stays ahead (stable)
    assign gt = !valid_reg || (value_reg > ins_value);

    // next slot contents
    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift) begin
            value_next = right_value;
            valid_next = right_valid;
        end else if (ctrl.insert && gt) begin
            if (left_gt) begin
                value_next = left_value;
                valid_next = left_valid;
            end else begin
                value_next = ins_value;
                valid_next = 1'b1;
            end
        end
    end

    // occupancy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // held value
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

### hw/rtl/merge_sorter_unit.sv
// The first sorted beat is offered in the cycle after the closing input beat is taken.
// One input beat per cycle is taken while loading, and one result beat per cycle
// is given while draining and m_ready is high; the cell chain sets both rates.
// Input is held off (s_ready low) for the whole drain of the sorted set.
// Reset (aresetn low, synchronous) empties every cell and returns to loading.
// ----------------------------------------------------------------------------
// merge_sorter_unit
// stable ascending sorter built from a chain of insertion cells
// ----------------------------------------------------------------------------
`include "merge_sorter_unit_macros.svh"

module merge_sorter_unit
    import msrt_pkg::*;
#(
    parameter int SET_SIZE = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    state_t             state_reg;
    state_t             state_next;
    cell_ctrl_t         ctrl;
    logic               in_beat;
    logic               out_beat;
    logic               last_beat;
    logic               full;
    logic signed [31:0] cell_value [SET_SIZE];
    logic [SET_SIZE-1:0] cell_valid;
    logic [SET_SIZE-1:0] cell_gt;

    // handshake
    assign s_ready   = (state_reg == ST_LOAD);
    assign m_valid   = (state_reg == ST_DRAIN) && cell_valid[0];
    assign in_beat   = s_valid && s_ready;
    assign out_beat  = m_valid && m_ready;
    assign last_beat = out_beat && m_data.last_out;
    assign full      = cell_valid[SET_SIZE-1];

    // chain command: a beat on a full chain is dropped
    assign ctrl.insert = in_beat && !full;
    assign ctrl.shift  = out_beat;

    // result beat comes straight from the head cell
    assign m_data.sorted_value = cell_value[0];
    assign m_data.last_out     = !cell_valid[1];

    // phase control
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_beat && (full || s_data.last)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (last_beat) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // cell chain
    for (genvar i = 0; i < SET_SIZE; i++) begin : g_cell
        logic               left_gt;
        logic signed [31:0] left_value;
        logic               left_valid;
        logic signed [31:0] right_value;
        logic               right_valid;

        if (i == 0) begin : g_head
            assign left_gt    = 1'b0;
            assign left_value = s_data.value;
            assign left_valid = 1'b0;
        end else begin : g_body
            assign left_gt    = cell_gt[i-1];
            assign left_value = cell_value[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == SET_SIZE - 1) begin : g_tail
            assign right_value = cell_value[i];
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
        end

        msrt_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .ins_value   (s_data.value),
            .left_gt     (left_gt),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .right_value (right_value),
            .right_valid (right_valid),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i])
        );
    end

    // checks
    `MSRT_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> s_ready && !cell_valid[0], "busy after reset")
    `MSRT_ASSERT(a_one_side, !(s_ready && m_valid), "load and drain overlap")
    `MSRT_ASSERT(a_fill_packed, ((cell_valid >> 1) & ~cell_valid) == '0, "gap in cell chain")
    `MSRT_ASSERT(a_last_drains, (in_beat && s_data.last) |=> m_valid, "closing beat not drained")
    `MSRT_ASSERT(a_end_reload, last_beat |=> s_ready && !cell_valid[0], "chain not emptied")

endmodule

### tb/sv/tb_merge_sorter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_merge_sorter_unit
// loads sets of signed words into the sorter and checks every sorted beat
// against a stable in-bench sort, with random idle bursts on both channels
// ----------------------------------------------------------------------------
module tb_merge_sorter_unit;
    import msrt_pkg::*;

    localparam int SET_SIZE     = 64;
    localparam int DIR_ROWS     = 21;
    localparam int RANDOM_BEATS = 320;
    localparam int QUIET_BEATS  = 40;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 60000;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               typed;
        logic signed [31:0] want;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    logic signed [31:0] held_q[$];
    out_beat_t          pending_q[$];
    out_beat_t          expect_q[$];
    stim_row_t          dir_rows [DIR_ROWS];

    int  err_count;
    int  cycle_count;
    int  beats_in;
    int  beats_out;
    int  set_count;
    int  drop_count;
    bit  quiet;
    bit  idle_on;

    merge_sorter_unit #(
        .SET_SIZE(SET_SIZE)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, expect_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stable sort of the set being loaded; a full buffer drops the beat and closes the set
    function automatic void predict_sorted(in_beat_t beat);
        logic signed [31:0] ordered[$];
        logic signed [31:0] v;
        out_beat_t          r;
        bit                 finish;
        int                 j;
        pending_q.delete();
        if (held_q.size() < SET_SIZE) begin
            held_q.push_back(beat.value);
            finish = beat.last;
        end else begin
            finish = 1'b1;
            drop_count++;
        end
        if (finish) begin
            // an equal value lands after those already placed, keeping load order
            foreach (held_q[i]) begin
                v = held_q[i];
                j = ordered.size();
                while (j > 0 && ordered[j-1] > v) j--;
                ordered.insert(j, v);
            end
            foreach (ordered[i]) begin
                r.sorted_value = ordered[i];
                r.last_out     = (i == ordered.size() - 1);
                pending_q.push_back(r);
            end
            held_q.delete();
            set_count++;
        end
    endfunction

    // mix of extremes, small values for ties and full-range words
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5: return $signed($urandom_range(0, 6)) - 32'sd3;
            default: return $urandom;
        endcase
    endfunction

    // drive one input beat, starting and ending at a falling edge
    task automatic send_beat(input logic signed [31:0] v, input logic lst,
                             input logic typed, input logic signed [31:0] want);
        in_beat_t  beat;
        out_beat_t r;
        int        gap;
        beat.value = v;
        beat.last  = lst;
        if (!quiet && idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        predict_sorted(beat);
        if (typed) begin
            r.sorted_value = want;
            r.last_out     = 1'b1;
            pending_q.delete();
            pending_q.push_back(r);
        end
        foreach (pending_q[i]) expect_q.push_back(pending_q[i]);
        beats_in++;
        @(negedge aclk);
    endtask

    // hold the sender until the sorter has drained everything
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expect_q.size() != 0) @(negedge aclk);
    endtask

    // result side back-pressure
    initial begin : result_ready
        int hold;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (quiet) begin
                m_ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                hold = $urandom_range(1, 3) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // compare each accepted result beat with the oldest expectation
    always @(posedge aclk) begin : check_results
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_out++;
            if (expect_q.size() == 0) begin
                err_count++;
                $display("%0t: result beat expected none got value %0d last %0b",
                         $time, m_data.sorted_value, m_data.last_out);
            end else begin
                want = expect_q.pop_front();
                if (m_data.sorted_value !== want.sorted_value) begin
                    err_count++;
                    $display("%0t: sorted_value expected %0d got %0d",
                             $time, want.sorted_value, m_data.sorted_value);
                end
                if (m_data.last_out !== want.last_out) begin
                    err_count++;
                    $display("%0t: last_out expected %0b got %0b",
                             $time, want.last_out, m_data.last_out);
                end
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int n;
        int rand_beats;
        int set_idx;
        logic lst;
        err_count   = 0;
        cycle_count = 0;
        beats_in    = 0;
        beats_out   = 0;
        set_count   = 0;
        drop_count  = 0;
        quiet       = 1'b0;
        idle_on     = 1'b1;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;

        dir_rows = '{
            // single-element sets come back unchanged
            '{32'sd0,        1'b1, 1'b1, 32'sd0},
            '{32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff},
            '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
            '{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff},
            // extremes around zero
            '{32'h7fff_ffff, 1'b0, 1'b0, 32'sd0},
            '{32'h8000_0000, 1'b0, 1'b0, 32'sd0},
            '{32'hffff_ffff, 1'b0, 1'b0, 32'sd0},
            '{32'sd0,        1'b1, 1'b0, 32'sd0},
            // repeated values
            '{32'sd5,        1'b0, 1'b0, 32'sd0},
            '{32'sd5,        1'b0, 1'b0, 32'sd0},
            '{-32'sd5,       1'b0, 1'b0, 32'sd0},
            '{32'sd5,        1'b1, 1'b0, 32'sd0},
            // already in order
            '{32'h8000_0000, 1'b0, 1'b0, 32'sd0},
            '{32'h7fff_ffff, 1'b1, 1'b0, 32'sd0},
            // alternating extremes with duplicates
            '{32'h7fff_ffff, 1'b0, 1'b0, 32'sd0},
            '{32'h8000_0000, 1'b0, 1'b0, 32'sd0},
            '{32'h7fff_ffff, 1'b0, 1'b0, 32'sd0},
            '{32'h8000_0000, 1'b1, 1'b0, 32'sd0},
            // small mixed signs
            '{32'sd3,        1'b0, 1'b0, 32'sd0},
            '{-32'sd3,       1'b0, 1'b0, 32'sd0},
            '{32'sd1,        1'b1, 1'b0, 32'sd0}
        };

        // reset
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        for (int k = 0; k < DIR_ROWS; k++)
            send_beat(dir_rows[k].value, dir_rows[k].last, dir_rows[k].typed,
                      dir_rows[k].want);
        wait_drained();

        // random sets, mostly small, one exactly full and one overflowing
        rand_beats = 0;
        set_idx    = 0;
        while (rand_beats < RANDOM_BEATS) begin
            if (set_idx == 3)
                n = SET_SIZE;
            else if (set_idx == 9)
                n = SET_SIZE + 1;
            else if ($urandom_range(0, 9) < 8)
                n = $urandom_range(1, 8);
            else
                n = $urandom_range(9, 32);
            idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < n; k++) begin
                lst = (k == n - 1);
                // the beat past a full buffer is dropped whatever its last bit
                if (n > SET_SIZE && k == n - 1)
                    lst = 1'($urandom_range(0, 1));
                send_beat(rand_value(), lst, 1'b0, 32'sd0);
            end
            rand_beats += n;
            set_idx++;
            quiet = (rand_beats >= RANDOM_BEATS - QUIET_BEATS);
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        s_valid <= 1'b0;

        // drain and let any stray beat show up
        while (expect_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sorted %0d sets from %0d input beats, %0d dropped on a full buffer",
                 set_count, beats_in, drop_count);
        $display("checked %0d result beats incl. single, full and overflowing sets",
                 beats_out);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### merge_sorter_unit.f
+incdir+hw/rtl
hw/rtl/msrt_pkg.sv
hw/rtl/msrt_cell.sv
hw/rtl/merge_sorter_unit.sv
tb/sv/tb_merge_sorter_unit.sv
